// ===== hdl/rliv_pkg.sv =====
// Shared types and constants for the run-length image validator.
`default_nettype none
package rliv_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  localparam logic [31:0] MAGIC_RST   = 32'h0000_0000;
  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam logic [15:0] LIMIT_RST   = 16'd4096;

  // Header byte positions
  localparam logic [3:0] HDR_VERSION   = 4'd4;
  localparam logic [3:0] HDR_PAD_LAST  = 4'd7;
  localparam logic [3:0] HDR_WIDTH_LO  = 4'd8;
  localparam logic [3:0] HDR_WIDTH_HI  = 4'd9;
  localparam logic [3:0] HDR_HEIGHT_LO = 4'd10;
  localparam logic [3:0] HDR_MAGIC_END = 4'd4;

  // Run byte positions
  localparam logic [2:0] RUN_LEN_LO = 3'd0;
  localparam logic [2:0] RUN_LEN_HI = 3'd1;
  localparam logic [2:0] RUN_LAST   = 3'd5;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUNS   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  format_version;
    logic [15:0] extent_limit;
  } cfg_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] run_total;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/rliv_cfg_regs.sv =====
// Configuration register bank of the validator.
`default_nettype none
module rliv_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [1:0]   wr_index,
  input  wire logic [31:0]  wr_data,
  output rliv_pkg::cfg_t    cfg
);
  import rliv_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_MAGIC:   cfg_nxt.magic_word     = wr_data;
        REG_VERSION: cfg_nxt.format_version = wr_data[7:0];
        REG_LIMIT:   cfg_nxt.extent_limit   = wr_data[15:0];
        default:     cfg_nxt = cfg_r;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word     <= MAGIC_RST;
      cfg_r.format_version <= VERSION_RST;
      cfg_r.extent_limit   <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hdl/rliv_parser.sv =====
// File parser: header and run checks, one byte per step, with the result of a final byte.
`default_nettype none
module rliv_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        is_last,
  input  rliv_pkg::cfg_t   cfg,
  output rliv_pkg::res_t   res
);
  import rliv_pkg::*;

  phase_t      phase_r,    phase_nxt;
  logic [3:0]  hdr_idx_r,  hdr_idx_nxt;
  logic [2:0]  run_idx_r,  run_idx_nxt;
  logic [15:0] width_r,    width_nxt;
  logic [15:0] height_r,   height_nxt;
  logic [15:0] row_fill_r, row_fill_nxt;
  logic [15:0] rows_r,     rows_nxt;
  logic [7:0]  len_lo_r,   len_lo_nxt;
  logic [31:0] runs_r,     runs_nxt;
  logic        failed_r,   failed_nxt;

  logic [7:0]  magic_byte;
  logic [15:0] run_len;
  logic [15:0] row_room;
  logic [15:0] new_height;
  logic [15:0] rows_inc;
  logic        ok;

  assign magic_byte = cfg.magic_word[{hdr_idx_r[1:0], 3'b000} +: 8];
  assign run_len    = {data_byte, len_lo_r};
  assign row_room   = width_r - row_fill_r;
  assign new_height = {data_byte, height_r[7:0]};
  assign rows_inc   = rows_r + 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    run_idx_nxt  = run_idx_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    row_fill_nxt = row_fill_r;
    rows_nxt     = rows_r;
    len_lo_nxt   = len_lo_r;
    runs_nxt     = runs_r;
    failed_nxt   = failed_r;

    if (!failed_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
          priority if (hdr_idx_r < HDR_MAGIC_END) begin
            if (data_byte != magic_byte) failed_nxt = 1'b1;
          end else if (hdr_idx_r == HDR_VERSION) begin
            if (data_byte != cfg.format_version) failed_nxt = 1'b1;
          end else if (hdr_idx_r <= HDR_PAD_LAST) begin
            if (data_byte != 8'd0) failed_nxt = 1'b1;
          end else if (hdr_idx_r == HDR_WIDTH_LO) begin
            width_nxt = {8'd0, data_byte};
          end else if (hdr_idx_r == HDR_WIDTH_HI) begin
            width_nxt = {data_byte, width_r[7:0]};
          end else if (hdr_idx_r == HDR_HEIGHT_LO) begin
            height_nxt = {8'd0, data_byte};
          end else begin
            height_nxt = new_height;
            if (width_r == 16'd0 || new_height == 16'd0 ||
                width_r > cfg.extent_limit || new_height > cfg.extent_limit) begin
              failed_nxt = 1'b1;
            end else begin
              phase_nxt    = PH_RUNS;
              row_fill_nxt = 16'd0;
              rows_nxt     = 16'd0;
              run_idx_nxt  = RUN_LEN_LO;
            end
          end
        end
        PH_RUNS: begin
          run_idx_nxt = (run_idx_r >= RUN_LAST) ? RUN_LEN_LO : run_idx_r + 3'd1;
          if (run_idx_r == RUN_LEN_LO) begin
            len_lo_nxt = data_byte;
          end else if (run_idx_r == RUN_LEN_HI) begin
            if (run_len == 16'd0 || run_len > row_room) failed_nxt = 1'b1;
            else row_fill_nxt = row_fill_r + run_len;
          end else if (run_idx_r == RUN_LAST) begin
            // colour word top byte must be zero
            if (data_byte != 8'd0) begin
              failed_nxt = 1'b1;
            end else begin
              runs_nxt = runs_r + 32'd1;
              if (row_fill_r == width_r) begin
                row_fill_nxt = 16'd0;
                rows_nxt     = rows_inc;
                if (rows_inc == height_r) phase_nxt = PH_DONE;
              end
            end
          end
        end
        PH_DONE:  failed_nxt = 1'b1;  // trailing byte
        default:  failed_nxt = 1'b1;
      endcase
    end

    ok                 = !failed_nxt && (phase_nxt == PH_DONE);
    res.valid_res      = ok;
    res.image_width    = ok ? width_nxt  : 16'd0;
    res.image_height   = ok ? height_nxt : 16'd0;
    res.run_total      = ok ? runs_nxt   : 32'd0;

    // final byte: start afresh for the next file
    if (is_last) begin
      phase_nxt    = PH_HEADER;
      hdr_idx_nxt  = 4'd0;
      run_idx_nxt  = 3'd0;
      width_nxt    = 16'd0;
      height_nxt   = 16'd0;
      row_fill_nxt = 16'd0;
      rows_nxt     = 16'd0;
      len_lo_nxt   = 8'd0;
      runs_nxt     = 32'd0;
      failed_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_idx_r  <= 4'd0;
      run_idx_r  <= 3'd0;
      width_r    <= 16'd0;
      height_r   <= 16'd0;
      row_fill_r <= 16'd0;
      rows_r     <= 16'd0;
      len_lo_r   <= 8'd0;
      runs_r     <= 32'd0;
      failed_r   <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      run_idx_r  <= run_idx_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      row_fill_r <= row_fill_nxt;
      rows_r     <= rows_nxt;
      len_lo_r   <= len_lo_nxt;
      runs_r     <= runs_nxt;
      failed_r   <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/run_length_image_validator_core.sv =====
// Top level of the run-length image validator.
// Takes one file byte per cycle while input is not held back: a request is
// held in an input register and checked by the parser as it leaves that
// register, the parser state updating once per byte. Only a byte marked last
// produces a result, which lands in the result register at the edge where
// that byte leaves the input register. Input is held back only when a final
// byte finds the result register still full and not being taken. Results
// are valid flag, width, height and run count, all zero on rejection.
// Configuration writes are taken in any cycle and should be made while no
// file is in flight.
`default_nettype none
module run_length_image_validator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_valid_res,
  output logic [15:0]      out_image_width,
  output logic [15:0]      out_image_height,
  output logic [31:0]      out_run_total,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rliv_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       step;
  logic       in_take;

  assign cfg_ready = 1'b1;

  rliv_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && (!in_last_r || out_free);
  assign in_ready = !in_valid_r || step;
  assign in_take  = in_valid && in_ready;

  rliv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .is_last   (in_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)   in_valid_nxt = 1'b1;
    else if (step) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (step && in_last_r) out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_is_last;
    end
    if (step && in_last_r) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_valid_res    = res_r.valid_res;
  assign out_image_width  = res_r.image_width;
  assign out_image_height = res_r.image_height;
  assign out_run_total    = res_r.run_total;

endmodule
`default_nettype wire

// ===== hdl/rliv_checker.sv =====
// Port-level checks for the validator top level, bound into it.
`default_nettype none
module rliv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_valid_res,
  input wire logic [15:0] out_image_width,
  input wire logic [15:0] out_image_height,
  input wire logic [31:0] out_run_total
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res) &&
      $stable(out_image_width) && $stable(out_image_height) && $stable(out_run_total))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      out_image_width == 16'd0 && out_image_height == 16'd0 && out_run_total == 32'd0)
    else $error("rejected file reports nonzero fields");

  // every row holds at least one run
  a_accept_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |->
      out_image_width != 16'd0 && out_image_height != 16'd0 &&
      {16'd0, out_image_height} <= out_run_total)
    else $error("accepted file reports impossible extent or run count");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind run_length_image_validator_core rliv_checker u_rliv_checker (.*);
`default_nettype wire

// ===== bench/run_length_image_validator_core_test.sv =====
// Self-checking testbench for the run-length image validator core.
`default_nettype none
module run_length_image_validator_core_test;
  import rliv_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  // Tracks the parser state per accepted byte and queues the verdict each
  // final byte should produce.
  class file_verdict_model;
    logic [31:0] magic;
    logic [7:0]  version;
    logic [15:0] limit;
    phase_t      phase;
    logic [3:0]  hdr_pos;
    logic [2:0]  run_pos;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] row_fill;
    logic [15:0] rows_done;
    logic [7:0]  len_lo;
    logic [31:0] runs;
    bit          failed;
    res_t        due[$];
    int          errors;

    function new();
      magic   = MAGIC_RST;
      version = VERSION_RST;
      limit   = LIMIT_RST;
      errors  = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_HEADER;
      hdr_pos   = '0;
      run_pos   = '0;
      width     = '0;
      height    = '0;
      row_fill  = '0;
      rows_done = '0;
      len_lo    = '0;
      runs      = '0;
      failed    = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        REG_MAGIC:   magic = d;
        REG_VERSION: version = d[7:0];
        REG_LIMIT:   limit = d[15:0];
        default: ;
      endcase
    endfunction

    function void header_byte(logic [7:0] b);
      logic [31:0] sh;
      sh = magic >> (8 * hdr_pos);
      if (hdr_pos < HDR_MAGIC_END) begin
        if (b != sh[7:0]) failed = 1'b1;
      end else if (hdr_pos == HDR_VERSION) begin
        if (b != version) failed = 1'b1;
      end else if (hdr_pos <= HDR_PAD_LAST) begin
        if (b != 8'h00) failed = 1'b1;
      end else if (hdr_pos == HDR_WIDTH_LO) begin
        width = {8'h00, b};
      end else if (hdr_pos == HDR_WIDTH_HI) begin
        width[15:8] = b;
      end else if (hdr_pos == HDR_HEIGHT_LO) begin
        height = {8'h00, b};
      end else begin
        height[15:8] = b;
        if (width == 0 || height == 0 || width > limit || height > limit) begin
          failed = 1'b1;
        end else begin
          phase     = PH_RUNS;
          row_fill  = '0;
          rows_done = '0;
          run_pos   = '0;
        end
      end
      hdr_pos = hdr_pos + 4'd1;
    endfunction

    function void run_byte(logic [7:0] b);
      logic [15:0] len;
      len = {b, len_lo};
      if (run_pos == RUN_LEN_LO) begin
        len_lo = b;
      end else if (run_pos == RUN_LEN_HI) begin
        if (len == 0 || len > width - row_fill) failed = 1'b1;
        else row_fill = row_fill + len;
      end else if (run_pos == RUN_LAST) begin
        // colour word must keep its top byte clear
        if (b != 8'h00) begin
          failed = 1'b1;
        end else begin
          runs = runs + 1;
          if (row_fill == width) begin
            row_fill  = '0;
            rows_done = rows_done + 16'd1;
            if (rows_done == height) phase = PH_DONE;
          end
        end
      end
      run_pos = (run_pos >= RUN_LAST) ? 3'd0 : run_pos + 3'd1;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      res_t v;
      if (!failed) begin
        case (phase)
          PH_HEADER: header_byte(b);
          PH_RUNS:   run_byte(b);
          default:   failed = 1'b1;
        endcase
      end
      if (last) begin
        v = '0;
        if (!failed && phase == PH_DONE) begin
          v.valid_res    = 1'b1;
          v.image_width  = width;
          v.image_height = height;
          v.run_total    = runs;
        end
        due.push_back(v);
        restart();
      end
    endfunction

    function void check_verdict(res_t got);
      res_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result valid %0b width %0d height %0d runs %0d", $time,
                 got.valid_res, got.image_width, got.image_height, got.run_total);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.valid_res !== want.valid_res) begin
        $display("%0t: valid_res expected %0b got %0b", $time, want.valid_res, got.valid_res);
        errors++;
      end
      if (got.image_width !== want.image_width) begin
        $display("%0t: image_width expected %0d got %0d", $time, want.image_width,
                 got.image_width);
        errors++;
      end
      if (got.image_height !== want.image_height) begin
        $display("%0t: image_height expected %0d got %0d", $time, want.image_height,
                 got.image_height);
        errors++;
      end
      if (got.run_total !== want.run_total) begin
        $display("%0t: run_total expected %0d got %0d", $time, want.run_total, got.run_total);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_valid_res;
  logic [15:0] out_image_width;
  logic [15:0] out_image_height;
  logic [31:0] out_run_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  file_verdict_model model;
  logic [7:0]        image_bytes[$];
  bit                calm = 1'b0;
  int                bytes_sent = 0;
  int                cycle_count = 0;

  run_length_image_validator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_run_total    (out_run_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Result side: sample at the edge, then choose ready for the next cycle.
  initial begin
    res_t got;
    int   stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        got.valid_res    = out_valid_res;
        got.image_width  = out_image_width;
        got.image_height = out_image_height;
        got.run_total    = out_run_total;
        model.check_verdict(got);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put16(input logic [15:0] v);
    image_bytes.push_back(v[7:0]);
    image_bytes.push_back(v[15:8]);
  endfunction

  function automatic void put_header(input logic [31:0] mg, input logic [7:0] ver,
                                     input logic [15:0] w, input logic [15:0] h);
    put16(mg[15:0]);
    put16(mg[31:16]);
    image_bytes.push_back(ver);
    image_bytes.push_back(8'h00);
    put16(16'h0000);
    put16(w);
    put16(h);
  endfunction

  function automatic void put_run(input logic [15:0] len, input logic [31:0] colour);
    put16(len);
    put16(colour[15:0]);
    put16(colour[31:16]);
  endfunction

  function automatic void put_rows(input int w, input int h);
    int row, rest, len;
    for (row = 0; row < h; row++) begin
      rest = w;
      while (rest > 0) begin
        len = ($urandom_range(0, 3) == 0) ? rest : $urandom_range(1, rest);
        put_run(len[15:0], $urandom & 32'h00FF_FFFF);
        rest -= len;
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_is_last   <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    model.take_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_image();
    int i;
    for (i = 0; i < image_bytes.size(); i++)
      send_byte(image_bytes[i], i == image_bytes.size() - 1);
    image_bytes.delete();
  endtask

  // Drain outstanding verdicts before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (model.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    model.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] mg, input logic [7:0] ver,
                          input logic [15:0] lim);
    settle();
    write_reg(REG_MAGIC, mg);
    write_reg(REG_VERSION, {24'h0, ver});
    write_reg(REG_LIMIT, {16'h0, lim});
  endtask

  task automatic directed_files();
    // smallest good file, colour bits all set below the top byte
    put_header(MAGIC_RST, VERSION_RST, 16'd1, 16'd1);
    put_run(16'd1, 32'h00FF_FFFF);
    send_image();
    // lone final byte
    image_bytes.push_back(8'hFF);
    send_image();
    // good 2x2 followed by a trailing byte
    put_header(MAGIC_RST, VERSION_RST, 16'd2, 16'd2);
    put_rows(2, 2);
    image_bytes.push_back(8'h00);
    send_image();
    // header only
    put_header(MAGIC_RST, VERSION_RST, 16'd3, 16'd2);
    send_image();
    // bad magic, then a body the parser must ignore
    put_header(32'h0000_0001, VERSION_RST, 16'd2, 16'd1);
    put_rows(2, 1);
    send_image();
    put_header(MAGIC_RST, 8'd2, 16'd1, 16'd1);
    put_run(16'd1, 32'h0);
    send_image();
    // padding byte not zero
    put_header(MAGIC_RST, VERSION_RST, 16'd1, 16'd1);
    image_bytes[6] = 8'h80;
    put_run(16'd1, 32'h0);
    send_image();
    put_header(MAGIC_RST, VERSION_RST, 16'd0, 16'd1);
    put_run(16'd1, 32'h0);
    send_image();
    put_header(MAGIC_RST, VERSION_RST, 16'd1, 16'd4097);
    put_run(16'd1, 32'h0);
    send_image();
    put_header(MAGIC_RST, VERSION_RST, 16'd4096, 16'd1);
    put_rows(4096, 1);
    send_image();
    put_header(MAGIC_RST, VERSION_RST, 16'd1, 16'd1);
    put_run(16'd0, 32'h0);
    send_image();
    put_header(MAGIC_RST, VERSION_RST, 16'd2, 16'd1);
    put_run(16'd3, 32'h0);
    send_image();
    put_header(MAGIC_RST, VERSION_RST, 16'd1, 16'd1);
    put_run(16'd1, 32'h0100_0000);
    send_image();
    // file stops part way through a row
    put_header(MAGIC_RST, VERSION_RST, 16'd3, 16'd1);
    put_run(16'd1, 32'h0);
    send_image();

    set_regs(32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    put_header(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'd1);
    put_run(16'hFFFF, 32'h00AA_5500);
    send_image();
    put_header(32'hFFFF_FFFF, 8'hFF, 16'd1, 16'hFFFF);
    put_run(16'd1, 32'h0);
    send_image();

    // a zero limit lets nothing through
    set_regs(32'hFFFF_FFFF, 8'hFF, 16'd0);
    put_header(32'hFFFF_FFFF, 8'hFF, 16'd1, 16'd1);
    put_run(16'd1, 32'h0);
    send_image();

    set_regs(32'h1234_5678, 8'h00, 16'd1);
    put_header(32'h1234_5678, 8'h00, 16'd1, 16'd1);
    put_run(16'd1, 32'h0);
    send_image();
    put_header(32'h1234_5678, 8'h00, 16'd2, 16'd1);
    put_rows(2, 1);
    send_image();
  endtask

  task automatic random_image();
    int w, h, r, lim, over, idx, n;
    lim  = model.limit;
    over = (lim < 65535) ? lim + 1 : 65535;
    calm = ($urandom_range(0, 4) == 0);

    r = $urandom_range(0, 99);
    if (r < 5) w = 0;
    else if (r < 12) w = over;
    else if (r < 22) w = $urandom_range(1, (lim > 0) ? lim : 1);
    else w = $urandom_range(1, 6);
    r = $urandom_range(0, 99);
    if (r < 5) h = 0;
    else if (r < 10) h = over;
    else h = $urandom_range(1, 4);

    put_header(model.magic, model.version, w[15:0], h[15:0]);
    if (w > 0 && h > 0 && w <= lim && h <= 8) begin
      put_rows(w, h);
    end else begin
      put_run(16'($urandom_range(0, 3)), $urandom);
      put_run(16'($urandom_range(0, 3)), $urandom);
    end

    r = $urandom_range(0, 99);
    if (r < 60) begin
      // left well formed
    end else if (r < 70) begin
      image_bytes[$urandom_range(0, image_bytes.size() - 1)] = 8'($urandom);
    end else if (r < 78) begin
      n = $urandom_range(1, image_bytes.size() - 1);
      while (image_bytes.size() > n) image_bytes.pop_back();
    end else if (r < 85) begin
      n = $urandom_range(1, 3);
      repeat (n) image_bytes.push_back(8'($urandom));
    end else if (r < 90) begin
      idx = 12 + 6 * $urandom_range(0, (image_bytes.size() - 12) / 6 - 1) + 5;
      image_bytes[idx] = 8'($urandom_range(1, 255));
    end else if (r < 95) begin
      idx = $urandom_range(0, 7);
      image_bytes[idx] = image_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    end else begin
      image_bytes.delete();
      n = $urandom_range(1, 16);
      repeat (n) image_bytes.push_back(8'($urandom));
    end
    send_image();
  endtask

  initial begin
    int p, start, images;
    logic [31:0] mg;
    logic [7:0]  ver;
    logic [15:0] lim;
    model = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_files();

    for (p = 0; p < 8; p++) begin
      mg  = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF : $urandom;
      ver = (p == 2) ? 8'h00 : (p == 3) ? 8'hFF : 8'($urandom_range(0, 255));
      case (p)
        0: lim = 16'd6;
        1: lim = 16'd1;
        2: lim = 16'd0;
        3: lim = 16'hFFFF;
        4: lim = LIMIT_RST;
        5: lim = 16'd2;
        6: lim = 16'($urandom_range(0, 65535));
        default: lim = 16'($urandom_range(3, 10));
      endcase
      set_regs(mg, ver, lim);
      start  = bytes_sent;
      images = 0;
      while (bytes_sent - start < 60 || images < 2) begin
        random_image();
        images++;
      end
    end

    calm = 1'b0;
    settle();
    if (model.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
